>>> sv/mmp_pkg.sv
// Shared constants, register codes and queue entry types for the masked pack block.
package mmp_pkg;

   localparam int MAX_DIMS    = 4;
   localparam int MAX_EXTENT  = 1024;
   localparam int DATA_WIDTH  = 64;

   localparam int DIM_W       = $clog2(MAX_DIMS);
   localparam int IDX_W       = $clog2(MAX_EXTENT);
   localparam int EXT_W       = 11;
   localparam int DCNT_W      = 3;
   localparam int POS_W       = 40;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 11;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_DIM_COUNT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_EXTENT_0  = 3'd1;

   // item kinds
   localparam logic REQ_MASK = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      logic                  keep;
      logic                  wrap;
   } mmp_entry_type;

   typedef struct packed {
      logic          valid;
      mmp_entry_type entry;
   } mmp_slot_type;

endpackage

>>> sv/mmp_if.sv
// Request and response channel interfaces of the masked pack block.
interface mmp_req_if;
   import mmp_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [DIM_W-1:0]             mask_dim;
   logic [IDX_W-1:0]             mask_index;
   logic                         mask_bit;
   logic signed [DATA_WIDTH-1:0] data_value;

   modport source (output valid, req_type, mask_dim, mask_index, mask_bit, data_value,
                   input ready);
   modport sink   (input valid, req_type, mask_dim, mask_index, mask_bit, data_value,
                   output ready);
endinterface

interface mmp_rsp_if;
   import mmp_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] packed_value;
   logic [POS_W-1:0]             packed_position;

   modport source (output valid, packed_value, packed_position, input ready);
   modport sink   (input valid, packed_value, packed_position, output ready);
endinterface

>>> sv/mmp_front.sv
// Front end: config registers, coordinate counters, mask memories and mask lookup stage.
module mmp_front (
   input  logic                           clock,
   input  logic                           reset,
   mmp_req_if.sink                        req,
   input  logic                           csr_write_en,
   input  logic [mmp_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [mmp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [mmp_pkg::QCNT_W-1:0]     q_count,
   output mmp_pkg::mmp_slot_type          push
);
   import mmp_pkg::*;

   logic [DCNT_W-1:0]     dim_count_ff, dim_count_in;
   logic [EXT_W-1:0]      ext_ff    [MAX_DIMS];
   logic [EXT_W-1:0]      ext_in    [MAX_DIMS];
   logic [EXT_W-1:0]      ext_lim   [MAX_DIMS];
   logic [IDX_W-1:0]      coord_ff  [MAX_DIMS];
   logic [IDX_W-1:0]      coord_in  [MAX_DIMS];
   logic [IDX_W-1:0]      coord_nxt [MAX_DIMS];
   logic [EXT_W-1:0]      step      [MAX_DIMS];
   logic                  rd_bit_ff [MAX_DIMS];
   logic [DCNT_W-1:0]     n_use;
   logic [MAX_DIMS-1:0]   in_use;
   logic                  wrap;
   logic                  keep;
   logic                  accept;
   logic                  accept_data;
   logic                  accept_mask;

   logic                  s1_valid_ff, s1_valid_in;
   logic [DATA_WIDTH-1:0] s1_value_ff;
   logic                  s1_wrap_ff;
   logic [MAX_DIMS-1:0]   s1_use_ff;

   // credit check: the lookup stage always lands in the queue next cycle
   assign req.ready   = (q_count + QCNT_W'(s1_valid_ff)) < QCNT_W'(QUEUE_DEPTH);
   assign accept      = req.valid && req.ready;
   assign accept_data = accept && (req.req_type == REQ_DATA);
   assign accept_mask = accept && (req.req_type == REQ_MASK);

   // config writes
   always_comb begin
      dim_count_in = dim_count_ff;
      if (csr_write_en && csr_index == CSR_DIM_COUNT) begin
         dim_count_in = csr_wdata[DCNT_W-1:0];
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         ext_in[d] = ext_ff[d];
         if (csr_write_en && csr_index == CSR_EXTENT_0 + CSR_ADDR_W'(d)) begin
            ext_in[d] = csr_wdata[EXT_W-1:0];
         end
      end
   end

   // clamp dimension count and extents
   always_comb begin
      if (dim_count_ff == '0) begin
         n_use = DCNT_W'(1);
      end else if (dim_count_ff > DCNT_W'(MAX_DIMS)) begin
         n_use = DCNT_W'(MAX_DIMS);
      end else begin
         n_use = dim_count_ff;
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         in_use[d] = DCNT_W'(d) < n_use;
         if (ext_ff[d] == '0) begin
            ext_lim[d] = EXT_W'(1);
         end else if (ext_ff[d] > EXT_W'(MAX_EXTENT)) begin
            ext_lim[d] = EXT_W'(MAX_EXTENT);
         end else begin
            ext_lim[d] = ext_ff[d];
         end
         step[d] = {1'b0, coord_ff[d]} + EXT_W'(1);
      end
   end

   // row-major stepping, last dimension in use fastest
   always_comb begin
      wrap = 1'b1;
      for (int d = MAX_DIMS - 1; d >= 0; d--) begin
         coord_nxt[d] = coord_ff[d];
         if (in_use[d] && wrap) begin
            if (step[d] >= ext_lim[d]) begin
               coord_nxt[d] = '0;
            end else begin
               coord_nxt[d] = step[d][IDX_W-1:0];
               wrap = 1'b0;
            end
         end
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (!accept_data) begin
            coord_in[d] = coord_ff[d];
         end else if (wrap) begin
            coord_in[d] = '0;
         end else begin
            coord_in[d] = coord_nxt[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= DCNT_W'(1);
         for (int d = 0; d < MAX_DIMS; d++) begin
            ext_ff[d]   <= EXT_W'(1);
            coord_ff[d] <= '0;
         end
      end else begin
         dim_count_ff <= dim_count_in;
         for (int d = 0; d < MAX_DIMS; d++) begin
            ext_ff[d]   <= ext_in[d];
            coord_ff[d] <= coord_in[d];
         end
      end
   end

   // one mask memory per dimension, one lookup each per item
   for (genvar g = 0; g < MAX_DIMS; g++) begin : g_mask
      logic mask_mem [MAX_EXTENT];

      always_ff @(posedge clock) begin
         if (accept_mask && req.mask_dim == DIM_W'(g)) begin
            mask_mem[req.mask_index] <= req.mask_bit;
         end
         if (accept_data) begin
            rd_bit_ff[g] <= mask_mem[coord_ff[g]];
         end
      end
   end

   assign s1_valid_in = accept_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_data) begin
         s1_value_ff <= req.data_value;
         s1_wrap_ff  <= wrap;
         s1_use_ff   <= in_use;
      end
   end

   always_comb begin
      keep = 1'b1;
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (s1_use_ff[d] && !rd_bit_ff[d]) begin
            keep = 1'b0;
         end
      end
   end

   assign push.valid       = s1_valid_ff;
   assign push.entry.value = s1_value_ff;
   assign push.entry.keep  = keep;
   assign push.entry.wrap  = s1_wrap_ff;

endmodule

>>> sv/mmp_queue.sv
// Small FIFO between the lookup front end and the output back end.
module mmp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  mmp_pkg::mmp_slot_type      push,
   input  logic                       pop,
   output mmp_pkg::mmp_slot_type      head,
   output logic [mmp_pkg::QCNT_W-1:0] count
);
   import mmp_pkg::*;

   mmp_entry_type     slots [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   // front end never pushes without a free slot
   assign do_push = push.valid;
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push.entry;
      end
   end

   assign head.valid = count_ff != '0;
   assign head.entry = slots[rd_ptr_ff];
   assign count      = count_ff;

endmodule

>>> sv/mmp_back.sv
// Back end: packed position counter and response output register.
module mmp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  mmp_pkg::mmp_slot_type head,
   output logic                  pop,
   mmp_rsp_if.source             rsp
);
   import mmp_pkg::*;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff;
   logic [POS_W-1:0]      rsp_pos_ff;
   logic [POS_W-1:0]      count_ff, count_in;
   logic                  emit;

   assign pop  = head.valid && (!rsp_valid_ff || rsp.ready);
   assign emit = pop && head.entry.keep;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
      count_in = count_ff;
      if (pop) begin
         if (head.entry.wrap) begin
            count_in = '0;
         end else if (head.entry.keep) begin
            count_in = count_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_value_ff <= head.entry.value;
         rsp_pos_ff   <= count_ff;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.packed_value    = rsp_value_ff;
   assign rsp.packed_position = rsp_pos_ff;

endmodule

>>> sv/masked_multidim_pack_top.sv
// Top level of the masked multi-dimensional pack block.
//
// Usage:
//  - csr_*: program dim_count (index 0) and extent_0..extent_3 (index 1..4) while idle.
//  - req_ch: mask items (req_type 0) set one keep bit of one dimension's mask;
//    data items (req_type 1) stream a row-major block, last dimension fastest.
//  - rsp_ch: one item per data element whose mask bits are all set, carrying the
//    element and its packed position within the current block.
// Throughput: one item per cycle sustained while rsp_ch.ready stays high. The front
//  end takes an item, steps the coordinate counters and reads the four mask memories in
//  the same cycle. An accepted item passes through the mask lookup stage, the 4-entry
//  queue and the output register before its result can be taken.
// Stall: when rsp_ch.ready is low the output register holds; the queue absorbs
//  items in flight and req_ch.ready drops once the queue credit runs out.
// Reset: clears counters, packed count, queue and output valid; registers go to
//  dim_count 1 and every extent 1. Mask memories are not cleared.
module masked_multidim_pack_top (
   input  logic                           clock,
   input  logic                           reset,
   mmp_req_if.sink                        req_ch,
   mmp_rsp_if.source                      rsp_ch,
   input  logic                           csr_write_en,
   input  logic [mmp_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [mmp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mmp_pkg::*;

   mmp_slot_type      push;
   mmp_slot_type      head;
   logic              pop;
   logic [QCNT_W-1:0] q_count;

   // accept, step coordinates, look up mask bits
   mmp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_count      (q_count),
      .push         (push)
   );

   // decouples lookup from a stalled output
   mmp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (q_count)
   );

   // assign packed positions and drive the response
   mmp_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

endmodule
